### rtl/core/iprsm_pkg.sv
package iprsm_pkg;

    // fixed field widths
    localparam int ADDR_W      = 32;
    localparam int SLOT_W      = 6;
    localparam int CITY_PORT_W = 8;

    // request kinds carried on s_axis_tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // input tdata layout, lowest bit up
    localparam int IN_SLOT_LSB   = 0;
    localparam int IN_ENABLE_BIT = IN_SLOT_LSB + SLOT_W;
    localparam int IN_START_LSB  = IN_ENABLE_BIT + 1;
    localparam int IN_END_LSB    = IN_START_LSB + ADDR_W;
    localparam int IN_CITY_LSB   = IN_END_LSB + ADDR_W;
    localparam int IN_QUERY_LSB  = IN_CITY_LSB + CITY_PORT_W;
    localparam int IN_DATA_W     = 112;

    // output tdata layout, lowest bit up
    localparam int OUT_CITY_LSB  = 0;
    localparam int OUT_WIDTH_LSB = OUT_CITY_LSB + CITY_PORT_W;
    localparam int OUT_DATA_W    = 40;

    // scan pipeline control toward the selector
    typedef struct packed {
        logic clear;     // new query, drop the running best
        logic rd_vld;    // memory read data is valid this cycle
        logic slot_vld;  // valid mark of the slot being read
        logic last;      // this read is the final slot of the scan
    } scan_ctl_t;

endpackage

### rtl/core/iprsm_ram.sv
module iprsm_ram #(
    parameter int WIDTH     = 72,
    parameter int DEPTH     = 64,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/iprsm_select.sv
module iprsm_select #(
    parameter int CITY_ID_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  iprsm_pkg::scan_ctl_t          ctl,
    input  logic [iprsm_pkg::ADDR_W-1:0]  q_addr,
    input  logic [iprsm_pkg::ADDR_W-1:0]  rd_start,
    input  logic [iprsm_pkg::ADDR_W-1:0]  rd_end,
    input  logic [CITY_ID_BITS-1:0]       rd_city,
    output logic                          done,
    output logic                          found,
    output logic [CITY_ID_BITS-1:0]       best_city,
    output logic [iprsm_pkg::ADDR_W-1:0]  best_width
);
    import iprsm_pkg::*;

    // containment and width stage
    logic                    s2_vld_reg;
    logic                    s2_hit_reg;
    logic                    s2_last_reg;
    logic [ADDR_W-1:0]       s2_width_reg;
    logic [CITY_ID_BITS-1:0] s2_city_reg;

    // running best
    logic                    found_reg;
    logic [ADDR_W-1:0]       best_width_reg;
    logic [CITY_ID_BITS-1:0] best_city_reg;
    logic                    take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg  <= 1'b0;
            s2_hit_reg  <= 1'b0;
            s2_last_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg  <= ctl.rd_vld;
            s2_hit_reg  <= ctl.rd_vld && ctl.slot_vld
                           && (q_addr >= rd_start) && (q_addr <= rd_end);
            s2_last_reg <= ctl.rd_vld && ctl.last;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_width_reg <= rd_end - rd_start;
        s2_city_reg  <= rd_city;
    end

    // strict less-than keeps the lowest slot on equal widths
    assign take = s2_vld_reg && s2_hit_reg && (!found_reg || (s2_width_reg < best_width_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_width_reg <= s2_width_reg;
            best_city_reg  <= s2_city_reg;
        end
    end

    assign done       = s2_vld_reg && s2_last_reg;
    assign found      = found_reg;
    assign best_city  = best_city_reg;
    assign best_width = best_width_reg;

endmodule

### rtl/core/ip_range_smallest_match_top.sv
// ip range table with smallest containing range lookup
//
// input channel s_axis: one request per handshake, s_axis_tuser picks the kind
//   write request: stores start, end and city id into a slot and sets or
//   clears its valid mark; it gives no result
//   query request: scans every slot of the table and returns one result
// output channel m_axis: found on m_axis_tuser, city id and width on tdata
// a query walks the table one slot per cycle through the single read port
// of the slot memory, then passes two pipeline stages (containment and
// width, best compare) and is loaded into the output register, where it
// drives m_axis_tvalid; the table has DEPTH = min(TABLE_SLOTS, 64) slots
// as the slot field reaches 64 slots at most; s_axis_tready rises in the
// same cycle as the result appears in the output register
// the block takes one request at a time; s_axis_tready is low during a scan
// if the receiver stalls, the result waits in the output register and a
// finished scan holds until that register frees up
// reset clears all valid marks (flip-flops), so no clearing pass is needed;
// slot contents are undefined until written
module ip_range_smallest_match_top #(
    parameter int TABLE_SLOTS  = 64,
    parameter int CITY_ID_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // slot, entry_enable, range_start, range_end, city_id, query_address, zero pad
    input  logic [iprsm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // cmd
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // match_city, match_width
    output logic [iprsm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // found
    output logic                                m_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready
);
    import iprsm_pkg::*;

    localparam int DEPTH  = (TABLE_SLOTS < 64) ? TABLE_SLOTS : 64;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WORD_W = 2 * ADDR_W + CITY_ID_BITS;
    localparam int CB_IN  = (CITY_ID_BITS < CITY_PORT_W) ? CITY_ID_BITS : CITY_PORT_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // request field split
    logic [SLOT_W-1:0]      in_slot;
    logic                   in_enable;
    logic [ADDR_W-1:0]      in_start;
    logic [ADDR_W-1:0]      in_end;
    logic [CITY_PORT_W-1:0] in_city;
    logic [ADDR_W-1:0]      in_query;

    assign in_slot   = s_axis_tdata[IN_SLOT_LSB +: SLOT_W];
    assign in_enable = s_axis_tdata[IN_ENABLE_BIT];
    assign in_start  = s_axis_tdata[IN_START_LSB +: ADDR_W];
    assign in_end    = s_axis_tdata[IN_END_LSB +: ADDR_W];
    assign in_city   = s_axis_tdata[IN_CITY_LSB +: CITY_PORT_W];
    assign in_query  = s_axis_tdata[IN_QUERY_LSB +: ADDR_W];

    logic in_acc;
    logic wr_acc;
    logic qry_acc;
    logic wr_en;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign wr_acc        = in_acc && (s_axis_tuser == CMD_WRITE);
    assign qry_acc       = in_acc && (s_axis_tuser == CMD_QUERY);
    // slots past the table are dropped
    assign wr_en         = wr_acc && ({26'd0, in_slot} < 32'(DEPTH));

    // city id kept to its stored width
    logic [CITY_ID_BITS-1:0] wr_city;
    always_comb
    begin
        wr_city            = '0;
        wr_city[CB_IN-1:0] = in_city[CB_IN-1:0];
    end

    // slot memory holds {city, end, start}
    logic [WORD_W-1:0] wr_word;
    logic [WORD_W-1:0] rd_word;
    logic [AW-1:0]     idx_reg;
    logic              rd_en;

    assign wr_word = {wr_city, in_end, in_start};
    assign rd_en   = (state_reg == S_SCAN);

    iprsm_ram #(
        .WIDTH     (WORD_W),
        .DEPTH     (DEPTH),
        .ADDR_BITS (AW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (in_slot[AW-1:0]),
        .wdata (wr_word),
        .re    (rd_en),
        .raddr (idx_reg),
        .rdata (rd_word)
    );

    // valid marks live in flip-flops so reset clears them at once
    logic [DEPTH-1:0] valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[in_slot[AW-1:0]] <= in_enable;
        end
    end

    logic scan_last;
    assign scan_last = (idx_reg == AW'(DEPTH - 1));

    // read stage control, aligned with the registered memory output
    logic rd_vld_reg;
    logic rd_slot_vld_reg;
    logic rd_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg      <= 1'b0;
            rd_slot_vld_reg <= 1'b0;
            rd_last_reg     <= 1'b0;
        end
        else
        begin
            rd_vld_reg      <= rd_en;
            rd_slot_vld_reg <= rd_en && valid_reg[idx_reg];
            rd_last_reg     <= rd_en && scan_last;
        end
    end

    // scan index and query address
    logic [ADDR_W-1:0] q_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (qry_acc)
        begin
            idx_reg <= '0;
        end
        else if (rd_en && !scan_last)
        begin
            idx_reg <= idx_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (qry_acc)
        begin
            q_addr_reg <= in_query;
        end
    end

    scan_ctl_t               sel_ctl;
    logic                    sel_done;
    logic                    sel_found;
    logic [CITY_ID_BITS-1:0] sel_city;
    logic [ADDR_W-1:0]       sel_width;

    assign sel_ctl.clear    = qry_acc;
    assign sel_ctl.rd_vld   = rd_vld_reg;
    assign sel_ctl.slot_vld = rd_slot_vld_reg;
    assign sel_ctl.last     = rd_last_reg;

    iprsm_select #(
        .CITY_ID_BITS (CITY_ID_BITS)
    ) u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (sel_ctl),
        .q_addr     (q_addr_reg),
        .rd_start   (rd_word[0 +: ADDR_W]),
        .rd_end     (rd_word[ADDR_W +: ADDR_W]),
        .rd_city    (rd_word[2*ADDR_W +: CITY_ID_BITS]),
        .done       (sel_done),
        .found      (sel_found),
        .best_city  (sel_city),
        .best_width (sel_width)
    );

    // output register, loaded once it is free
    logic                   out_vld_reg;
    logic                   out_found_reg;
    logic [CITY_PORT_W-1:0] out_city_reg;
    logic [ADDR_W-1:0]      out_width_reg;
    logic                   out_load;
    logic [CITY_PORT_W-1:0] res_city;

    assign out_load = (state_reg == S_DONE) && (!out_vld_reg || m_axis_tready);

    always_comb
    begin
        res_city = '0;
        if (sel_found)
        begin
            res_city[CB_IN-1:0] = sel_city[CB_IN-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (qry_acc)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (sel_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_found_reg <= sel_found;
            out_city_reg  <= res_city;
            out_width_reg <= sel_found ? sel_width : '0;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tdata  = {out_width_reg, out_city_reg};

    // the selector only finishes once the scan has issued its last read
    a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        sel_done |-> (state_reg == S_DRAIN))
        else $error("scan finished outside drain");

    // memory data is only marked valid in the cycle after a scan read
    a_read_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> $past(state_reg == S_SCAN))
        else $error("read data without a scan read");

    // a finished query always lands in the output register
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_vld_reg && (state_reg == S_IDLE)))
        else $error("result not loaded");

endmodule
